// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // field widths of one entry
    localparam int PRIORITY_BITS = 8;
    localparam int PAYLOAD_BITS  = 32;
    localparam int COUNT_BITS    = 5;

    // default number of slots
    localparam int QUEUE_DEPTH_DEF = 16;

    // action codes on the input field
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // operation handed from front to back
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                     action;
        logic [PRIORITY_BITS-1:0] entry_priority;
        logic [PAYLOAD_BITS-1:0]  entry_payload;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic                     out_valid;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [PAYLOAD_BITS-1:0]  out_payload;
        logic [COUNT_BITS-1:0]    held_count;
    } t_out_item;

    // classified request waiting for the back end
    typedef struct packed {
        t_op                      op;
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  payload;
    } t_cmd;

    // front-to-back request channel
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// File: hdl/spq_front.sv
`timescale 1ns / 1ps

module spq_front
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output t_cmd_chan o_chan,
    input  logic      i_pop
);

    // two-entry request queue
    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    logic push;
    logic pop;
    t_cmd cmd_in;

    // classify the incoming request
    always_comb begin
        cmd_in.op      = (i_item.action == ACT_DEQ) ? OP_DEQ : OP_ENQ;
        cmd_in.prio    = i_item.entry_priority;
        cmd_in.payload = i_item.entry_payload;
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != 2'd0);

    assign o_chan.valid = (r_cnt != 2'd0);
    assign o_chan.cmd   = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/spq_back.sv
`timescale 1ns / 1ps

module spq_back
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_chan i_chan,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // sorted cell array, slot 0 is the head
    logic [PRIORITY_BITS-1:0] r_slot_prio [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  r_slot_pay  [QUEUE_DEPTH];
    logic [CW-1:0]            r_occ;
    logic [CW-1:0]            n_occ;

    logic      r_res_valid;
    t_out_item r_res;
    t_out_item n_res;

    logic                   take;
    logic                   full;
    logic                   empty;
    logic                   do_enq;
    logic                   do_deq;
    logic [QUEUE_DEPTH-1:0] ge;
    logic [CW+COUNT_BITS-1:0] count_ext;

    assign take   = i_chan.valid && (!r_res_valid || !i_stall);
    assign o_pop  = take;
    assign full   = (r_occ == DEPTH_C);
    assign empty  = (r_occ == '0);
    assign do_enq = take && (i_chan.cmd.op == OP_ENQ) && !full;
    assign do_deq = take && (i_chan.cmd.op == OP_DEQ) && !empty;

    // each cell compares its held entry against the new priority
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);

        assign ge[i] = (IDX < r_occ) && (r_slot_prio[i] >= i_chan.cmd.prio);

        always_ff @(posedge i_clk) begin
            if (do_enq && !ge[i]) begin
                if (i == 0) begin
                    r_slot_prio[i] <= i_chan.cmd.prio;
                    r_slot_pay[i]  <= i_chan.cmd.payload;
                end else if (ge[(i == 0) ? 0 : i-1]) begin
                    r_slot_prio[i] <= i_chan.cmd.prio;
                    r_slot_pay[i]  <= i_chan.cmd.payload;
                end else begin
                    r_slot_prio[i] <= r_slot_prio[(i == 0) ? 0 : i-1];
                    r_slot_pay[i]  <= r_slot_pay[(i == 0) ? 0 : i-1];
                end
            end else if (do_deq && (i < QUEUE_DEPTH - 1)) begin
                r_slot_prio[i] <= r_slot_prio[(i < QUEUE_DEPTH - 1) ? i+1 : i];
                r_slot_pay[i]  <= r_slot_pay[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            end
        end
    end

    // next occupancy
    always_comb begin
        n_occ = r_occ;
        if (do_enq) begin
            n_occ = r_occ + 1'b1;
        end else if (do_deq) begin
            n_occ = r_occ - 1'b1;
        end
    end

    assign count_ext = {{COUNT_BITS{1'b0}}, n_occ};

    // result of the request being taken
    always_comb begin
        n_res              = '0;
        n_res.status       = ST_DONE;
        n_res.held_count   = count_ext[COUNT_BITS-1:0];
        unique case (i_chan.cmd.op)
            OP_ENQ: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end
            end
            OP_DEQ: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.out_valid    = 1'b1;
                    n_res.out_priority = r_slot_prio[0];
                    n_res.out_payload  = r_slot_pay[0];
                end
            end
            default: n_res.status = ST_DONE;
        endcase
    end

    // occupancy and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (take) begin
                r_res_valid <= 1'b1;
            end else if (!i_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_valid;
    assign o_item  = r_res;

    // occupancy stays within the slot count
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_C)
        else $error("occupancy beyond depth");

    // a served dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_deq |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("dequeue count mismatch");

    // an enqueue into a full array is reported as full
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_chan.cmd.op == OP_ENQ) && full)
            |=> (r_res.status == ST_FULL) && (r_occ == DEPTH_C))
        else $error("full enqueue not flagged");

    // a returned entry always comes with done status
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.out_valid) |-> (r_res.status == ST_DONE))
        else $error("returned entry with error status");

endmodule

// File: hdl/stable_priority_queue.sv
`timescale 1ns / 1ps

// Stable bounded priority queue with QUEUE_DEPTH slots. Each request either
// enqueues a (priority, payload) entry or dequeues the head; entries leave in
// descending priority, equal priorities in arrival order. Every request gives
// exactly one result: status done, full (enqueue rejected) or empty (dequeue
// with nothing held), the dequeued entry when there is one, and the count held
// afterwards. A two-entry request queue feeds a sorted cell array in which all
// slots compare and shift in parallel, so the array serves one request per
// cycle and sustains that rate while the result side does not stall; a
// result is registered as the array takes its request. The slot storage needs
// no clearing after reset; only slots below the held count are ever read.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_cmd_chan chan;
    logic      pop;

    // request intake and classification
    spq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_chan  (chan),
        .i_pop   (pop)
    );

    // sorted cell array and result register
    spq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chan  (chan),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

// File: tb/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;
    import spq_pkg::*;

    // tracks the sorted slots and the results that must come back, in order
    class queue_scoreboard;
        logic [PRIORITY_BITS-1:0] slot_prio [QUEUE_DEPTH_DEF];
        logic [PAYLOAD_BITS-1:0]  slot_pay  [QUEUE_DEPTH_DEF];
        int                       held;
        t_out_item                pending[$];
        int                       mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        // work out the result of an accepted request and update the slots
        function void note_request(t_in_item req);
            t_out_item res;
            int        pos;
            res        = '0;
            res.status = ST_DONE;
            if (req.action == ACT_ENQ) begin
                if (held >= QUEUE_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held && slot_prio[pos] >= req.entry_priority) pos++;
                    for (int i = held; i > pos; i--) begin
                        slot_prio[i] = slot_prio[i-1];
                        slot_pay[i]  = slot_pay[i-1];
                    end
                    slot_prio[pos] = req.entry_priority;
                    slot_pay[pos]  = req.entry_payload;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_valid    = 1'b1;
                    res.out_priority = slot_prio[0];
                    res.out_payload  = slot_pay[0];
                    for (int i = 1; i < held; i++) begin
                        slot_prio[i-1] = slot_prio[i];
                        slot_pay[i-1]  = slot_pay[i];
                    end
                    held--;
                end
            end
            res.held_count = held[COUNT_BITS-1:0];
            pending.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one accepted result against the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, want.status));
                if (got.out_valid !== want.out_valid)
                    report_mismatch($sformatf("out_valid got %0b want %0b",
                                              got.out_valid, want.out_valid));
                if (got.out_priority !== want.out_priority)
                    report_mismatch($sformatf("out_priority got %0h want %0h",
                                              got.out_priority, want.out_priority));
                if (got.out_payload !== want.out_payload)
                    report_mismatch($sformatf("out_payload got %0h want %0h",
                                              got.out_payload, want.out_payload));
                if (got.held_count !== want.held_count)
                    report_mismatch($sformatf("held_count got %0d want %0d",
                                              got.held_count, want.held_count));
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    queue_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;

    stable_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hand one request to the queue and wait until it is taken
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic send_fields(input logic act, input logic [PRIORITY_BITS-1:0] prio,
                               input logic [PAYLOAD_BITS-1:0] pay);
        t_in_item req;
        req.action         = act;
        req.entry_priority = prio;
        req.entry_payload  = pay;
        send_request(req);
    endtask

    // random request; priorities cluster at times so that ties are common
    function automatic t_in_item make_request(int enq_pct);
        t_in_item req;
        req.action = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
        case ($urandom_range(3))
            0: req.entry_priority = PRIORITY_BITS'($urandom_range(3));
            1: req.entry_priority = PRIORITY_BITS'(8'hff - $urandom_range(3));
            2: req.entry_priority = PRIORITY_BITS'(8'h80 + $urandom_range(1));
            default: req.entry_priority = PRIORITY_BITS'($urandom);
        endcase
        req.entry_payload = PAYLOAD_BITS'($urandom);
        return req;
    endfunction

    // bursts that fill, drain or mix so that full and empty are both reached
    task automatic run_random(input int count);
        int sent;
        int burst;
        int enq_pct;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(15, 40);
            case ($urandom_range(2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int i = 0; i < burst && sent < count; i++) begin
                send_request(make_request(enq_pct));
                sent++;
            end
        end
    endtask

    // result side: random stalls, check every accepted result
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // main sequence
    initial begin
        int wait_cycles;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue on empty, extremes, ties in both orders, drain past empty
        send_fields(ACT_DEQ, 8'h00, 32'h0000_0000);
        send_fields(ACT_ENQ, 8'h00, 32'h0000_0000);
        send_fields(ACT_ENQ, 8'hff, 32'hffff_ffff);
        send_fields(ACT_ENQ, 8'h80, 32'ha5a5_a5a5);
        send_fields(ACT_ENQ, 8'h80, 32'h5a5a_5a5a);
        send_fields(ACT_ENQ, 8'hff, 32'h0000_0001);
        send_fields(ACT_ENQ, 8'h00, 32'h0000_0002);
        repeat (7) send_fields(ACT_DEQ, 8'hff, 32'hffff_ffff);

        // sender idles lightly, receiver heavily, then swapped, then neither
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 8;  recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_random(130);
        end
        i_valid <= 1'b0;

        // drain outstanding results
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
